/* rtl/nmp_pkg.sv */
// Package for the neighborhood max pool: sizes, codes, microcode word and program ROM.
// Depends on nothing; used by neighborhood_max_pool_argmax.
package nmp_pkg;

    localparam int MAX_POINTS    = 1024;
    localparam int MAX_NEIGHBORS = 16;
    localparam int MAX_CHANNELS  = 64;
    localparam int FEATURE_WIDTH = 16;

    localparam int PT_W   = $clog2(MAX_POINTS);
    localparam int NB_W   = $clog2(MAX_NEIGHBORS);
    localparam int CH_W   = $clog2(MAX_CHANNELS);
    localparam int CNT_W  = PT_W + 1;
    localparam int FE_AW  = CH_W + PT_W;
    localparam int NB_AW  = NB_W + PT_W;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DW    = 11;
    localparam int PC_CFG_W  = 11;
    localparam int NC_CFG_W  = 5;
    localparam int CC_CFG_W  = 7;

    localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NEIGHBOR_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT  = 2'd2;

    localparam logic [1:0] MODE_LOAD_FEAT = 2'd0;
    localparam logic [1:0] MODE_LOAD_NB   = 2'd1;
    localparam logic [1:0] MODE_POOL      = 2'd2;

    localparam logic signed [FEATURE_WIDTH-1:0] FEAT_LOWEST =
        {1'b1, {(FEATURE_WIDTH-1){1'b0}}};

    typedef logic [2:0] upc_t;

    localparam upc_t UPC_IDLE  = 3'd0;
    localparam upc_t UPC_NB    = 3'd1;
    localparam upc_t UPC_INIT  = 3'd2;
    localparam upc_t UPC_SCAN  = 3'd3;
    localparam upc_t UPC_DRAIN = 3'd4;
    localparam upc_t UPC_EMIT  = 3'd5;
    localparam upc_t UPC_NEXT  = 3'd6;
    localparam upc_t UPC_DONE  = 3'd7;

    typedef enum logic [2:0] {
        COND_NONE,
        COND_ALWAYS,
        COND_NO_GO,
        COND_K_MORE,
        COND_OUT_BUSY,
        COND_CH_MORE
    } cond_t;

    typedef struct packed {
        logic  s_rdy;
        logic  nb_rd;
        logic  init;
        logic  fe_rd;
        logic  emit;
        logic  ch_next;
        cond_t cond;
        upc_t  target;
    } uword_t;

    function automatic uword_t ucode_rom(input upc_t pc);
        uword_t w;
        w = '0;
        unique case (pc)
            UPC_IDLE: begin
                w.s_rdy  = 1'b1;
                w.cond   = COND_NO_GO;
                w.target = UPC_IDLE;
            end
            UPC_NB: begin
                w.nb_rd  = 1'b1;
                w.cond   = COND_K_MORE;
                w.target = UPC_NB;
            end
            UPC_INIT: begin
                w.init   = 1'b1;
            end
            UPC_SCAN: begin
                w.fe_rd  = 1'b1;
                w.cond   = COND_K_MORE;
                w.target = UPC_SCAN;
            end
            UPC_DRAIN: begin
                w.cond   = COND_NONE;
            end
            UPC_EMIT: begin
                w.emit   = 1'b1;
                w.cond   = COND_OUT_BUSY;
                w.target = UPC_EMIT;
            end
            UPC_NEXT: begin
                w.ch_next = 1'b1;
                w.cond    = COND_CH_MORE;
                w.target  = UPC_SCAN;
            end
            UPC_DONE: begin
                w.cond   = COND_ALWAYS;
                w.target = UPC_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

/* rtl/neighborhood_max_pool_argmax.sv */
// Top level of the neighborhood max pool with argmax: feature store, neighbor table,
// microcoded sequencer and output register. Depends on nmp_pkg.
//
//   channel   ports                                        role
//   s_        s_valid s_ready s_mode s_point s_slot ...     load beats and pool requests
//   m_        m_valid m_ready m_pooled_value ... m_last     one beat per active channel
//   cfg_      cfg_wr_en cfg_index cfg_wdata                 count registers, write only
//
// A pool request reads the neighbor list, then scans it once per channel through the
// single read port of the feature store: one feature read per cycle. The block takes
// no new beat until the last result of a pool request is registered. A stalled m_
// channel holds the sequencer in its emit step. Reset is synchronous, clears control
// registers, sets the counts to their maxima; both stores hold garbage until written.
module neighborhood_max_pool_argmax (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     cfg_wr_en,
    input  logic [nmp_pkg::CFG_IDX_W-1:0]            cfg_index,
    input  logic [nmp_pkg::CFG_DW-1:0]               cfg_wdata,
    input  logic                                     s_valid,
    output logic                                     s_ready,
    input  logic [1:0]                               s_mode,
    input  logic [nmp_pkg::PT_W-1:0]                 s_point,
    input  logic [5:0]                               s_slot,
    input  logic signed [nmp_pkg::FEATURE_WIDTH-1:0] s_feature_value,
    input  logic [nmp_pkg::PT_W-1:0]                 s_neighbor_id,
    output logic                                     m_valid,
    input  logic                                     m_ready,
    output logic signed [nmp_pkg::FEATURE_WIDTH-1:0] m_pooled_value,
    output logic [nmp_pkg::PT_W-1:0]                 m_winner_id,
    output logic [nmp_pkg::CH_W-1:0]                 m_channel,
    output logic                                     m_last
);
    import nmp_pkg::*;

    logic signed [FEATURE_WIDTH-1:0] feature_mem [2**FE_AW];
    logic [PT_W-1:0]                 nb_mem [2**NB_AW];
    logic [PT_W-1:0]                 nb_ids_reg [MAX_NEIGHBORS];

    upc_t                            upc_reg, upc_next;
    uword_t                          uw;
    logic                            take;

    logic [CNT_W-1:0]                npts_reg, npts_next;
    logic [NB_W-1:0]                 nnb_last_reg, nnb_last_next;
    logic [CH_W-1:0]                 ch_last_reg, ch_last_next;
    logic [PC_CFG_W-1:0]             pc_cfg;
    logic [NC_CFG_W-1:0]             nc_cfg;
    logic [CC_CFG_W-1:0]             cc_cfg;

    logic [PT_W-1:0]                 point_reg, point_next;
    logic [NB_W-1:0]                 k_reg, k_next;
    logic [CH_W-1:0]                 c_reg, c_next;
    logic signed [FEATURE_WIDTH-1:0] best_reg, best_next;
    logic [PT_W-1:0]                 best_id_reg, best_id_next;

    logic                            nb_cap_reg;
    logic [NB_W-1:0]                 nb_k_d_reg;
    logic [PT_W-1:0]                 nb_rdata_reg;
    logic                            fe_vld_reg;
    logic [PT_W-1:0]                 fe_id_reg;
    logic signed [FEATURE_WIDTH-1:0] fe_rdata_reg;

    logic                            m_valid_reg, m_valid_next;
    logic signed [FEATURE_WIDTH-1:0] m_value_reg;
    logic [PT_W-1:0]                 m_id_reg;
    logic [CH_W-1:0]                 m_ch_reg;
    logic                            m_last_reg;

    logic                            s_acc;
    logic                            pool_go;
    logic                            fe_we;
    logic                            nb_we;
    logic                            out_free;
    logic                            emit_fire;
    logic [PT_W-1:0]                 cur_id;
    logic                            cur_skip;

    assign uw       = ucode_rom(upc_reg);
    assign s_ready  = uw.s_rdy;
    assign s_acc    = s_valid && uw.s_rdy;
    assign pool_go  = s_acc && (s_mode == MODE_POOL) && ({1'b0, s_point} < npts_reg);
    assign fe_we    = s_acc && (s_mode == MODE_LOAD_FEAT) && (32'(s_slot) < MAX_CHANNELS)
                      && (32'(s_point) < MAX_POINTS);
    assign nb_we    = s_acc && (s_mode == MODE_LOAD_NB) && (32'(s_slot) < MAX_NEIGHBORS)
                      && (32'(s_point) < MAX_POINTS);
    assign out_free  = !m_valid_reg || m_ready;
    assign emit_fire = uw.emit && out_free;
    assign cur_id    = nb_ids_reg[k_reg];
    assign cur_skip  = ({1'b0, cur_id} >= npts_reg);

    assign pc_cfg = cfg_wdata[PC_CFG_W-1:0];
    assign nc_cfg = cfg_wdata[NC_CFG_W-1:0];
    assign cc_cfg = cfg_wdata[CC_CFG_W-1:0];

    // Count registers: hold clamped values, last index for neighbors and channels
    always_comb begin
        npts_next     = npts_reg;
        nnb_last_next = nnb_last_reg;
        ch_last_next  = ch_last_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_POINT_COUNT: begin
                    if (pc_cfg == '0)
                        npts_next = CNT_W'(1);
                    else if (32'(pc_cfg) > MAX_POINTS)
                        npts_next = CNT_W'(MAX_POINTS);
                    else
                        npts_next = CNT_W'(pc_cfg);
                end
                REG_NEIGHBOR_COUNT: begin
                    if (nc_cfg == '0)
                        nnb_last_next = '0;
                    else if (32'(nc_cfg) > MAX_NEIGHBORS)
                        nnb_last_next = NB_W'(MAX_NEIGHBORS - 1);
                    else
                        nnb_last_next = NB_W'(nc_cfg - NC_CFG_W'(1));
                end
                REG_CHANNEL_COUNT: begin
                    if (cc_cfg == '0)
                        ch_last_next = '0;
                    else if (32'(cc_cfg) > MAX_CHANNELS)
                        ch_last_next = CH_W'(MAX_CHANNELS - 1);
                    else
                        ch_last_next = CH_W'(cc_cfg - CC_CFG_W'(1));
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (uw.cond)
            COND_NONE:     take = 1'b0;
            COND_ALWAYS:   take = 1'b1;
            COND_NO_GO:    take = !pool_go;
            COND_K_MORE:   take = (k_reg != nnb_last_reg);
            COND_OUT_BUSY: take = !out_free;
            COND_CH_MORE:  take = (c_reg != ch_last_reg);
            default:       take = 1'b0;
        endcase
        upc_next = take ? uw.target : upc_t'(upc_reg + 3'd1);
    end

    always_comb begin
        point_next   = point_reg;
        k_next       = k_reg;
        c_next       = c_reg;
        best_next    = best_reg;
        best_id_next = best_id_reg;
        m_valid_next = m_valid_reg && !m_ready;

        if (pool_go) begin
            point_next = s_point;
            k_next     = '0;
        end
        if (uw.nb_rd || uw.fe_rd)
            k_next = NB_W'(k_reg + NB_W'(1));
        // compare stage: strictly greater wins, ties keep the earlier slot
        if (fe_vld_reg && (fe_rdata_reg > best_reg)) begin
            best_next    = fe_rdata_reg;
            best_id_next = fe_id_reg;
        end
        if (uw.init || uw.ch_next) begin
            k_next       = '0;
            best_next    = FEAT_LOWEST;
            best_id_next = '0;
            c_next       = uw.init ? '0 : CH_W'(c_reg + CH_W'(1));
        end
        if (emit_fire)
            m_valid_next = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg      <= UPC_IDLE;
            npts_reg     <= CNT_W'(MAX_POINTS);
            nnb_last_reg <= NB_W'(MAX_NEIGHBORS - 1);
            ch_last_reg  <= CH_W'(MAX_CHANNELS - 1);
            m_valid_reg  <= 1'b0;
            nb_cap_reg   <= 1'b0;
            fe_vld_reg   <= 1'b0;
        end else begin
            upc_reg      <= upc_next;
            npts_reg     <= npts_next;
            nnb_last_reg <= nnb_last_next;
            ch_last_reg  <= ch_last_next;
            m_valid_reg  <= m_valid_next;
            nb_cap_reg   <= uw.nb_rd;
            fe_vld_reg   <= uw.fe_rd && !cur_skip;
        end
        point_reg   <= point_next;
        k_reg       <= k_next;
        c_reg       <= c_next;
        best_reg    <= best_next;
        best_id_reg <= best_id_next;
        nb_k_d_reg  <= k_reg;
        fe_id_reg   <= cur_id;
        if (emit_fire) begin
            m_value_reg <= best_reg;
            m_id_reg    <= best_id_reg;
            m_ch_reg    <= c_reg;
            m_last_reg  <= (c_reg == ch_last_reg);
        end
        if (nb_cap_reg)
            nb_ids_reg[nb_k_d_reg] <= nb_rdata_reg;
    end

    always_ff @(posedge aclk) begin
        if (fe_we)
            feature_mem[{s_slot[CH_W-1:0], s_point}] <= s_feature_value;
        if (uw.fe_rd)
            fe_rdata_reg <= feature_mem[{c_reg, cur_id}];
    end

    always_ff @(posedge aclk) begin
        if (nb_we)
            nb_mem[{s_slot[NB_W-1:0], s_point}] <= s_neighbor_id;
        if (uw.nb_rd)
            nb_rdata_reg <= nb_mem[{k_reg, point_reg}];
    end

    assign m_valid        = m_valid_reg;
    assign m_pooled_value = m_value_reg;
    assign m_winner_id    = m_id_reg;
    assign m_channel      = m_ch_reg;
    assign m_last         = m_last_reg;

endmodule
